FILE: design/srt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sparse radix table.
// No dependencies; imported by the node store and the top level.
package srt_pkg;

    // number of tree levels; the index is cut into this many digits
    localparam int LEVELS  = 4;
    localparam int INDEX_W = 16;
    localparam int DATA_W  = 32;

    // operation codes carried in the input tuser
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // one word of the node store: valid mark and payload or child number
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } entry_t;

endpackage

FILE: design/srt_store.sv
`timescale 1ns / 1ps
// Node store of the sparse radix table: one synchronous memory of entry_t words.
// Runs a clearing pass after reset; depends on srt_pkg.
module srt_store
    import srt_pkg::*;
#(
    parameter int BLOCK_BITS = 4,
    parameter int NODE_COUNT = 256
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [$clog2(NODE_COUNT)+BLOCK_BITS-1:0]    addr,
    input  logic                                        wr_en,
    input  entry_t                                      wr_data,
    output entry_t                                      rd_data,
    output logic                                        busy
);

    localparam int STORE_DEPTH = NODE_COUNT << BLOCK_BITS;
    localparam int STORE_AW    = $clog2(NODE_COUNT) + BLOCK_BITS;
    localparam logic [STORE_AW-1:0] LAST_ADDR = STORE_AW'(STORE_DEPTH - 1);

    entry_t                mem [STORE_DEPTH];
    entry_t                rd_data_reg;
    logic [STORE_AW-1:0]   clr_addr_reg;
    logic [STORE_AW-1:0]   clr_addr_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic [STORE_AW-1:0]   mem_addr;
    logic                  mem_we;
    entry_t                mem_wdata;

    // clearing pass walks every entry once after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // port select: clearing pass owns the memory while busy
    always_comb
    begin
        mem_addr  = busy_reg ? clr_addr_reg : addr;
        mem_we    = busy_reg | wr_en;
        mem_wdata = busy_reg ? entry_t'('0) : wr_data;
    end

    // single port memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

FILE: design/sparse_radix_table.sv
`timescale 1ns / 1ps
// Top level of the sparse radix table: walk and allocate sequencer plus output register.
// Depends on srt_pkg and srt_store.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser selects read or write,
//   s_tdata carries the index and the payload. Each item yields one result
//   item on m_tvalid/m_tready: found and pool_full in m_tuser, the read
//   payload in m_tdata (zero on a miss and on every write).
//   One item is worked at a time. A read visits each tree level with an
//   address issue, then a check of the registered memory word, and then
//   loads the output register. A write takes the same walk, writes a link
//   for each node it allocates, then the leaf entry, and loads the output.
//   The next item is accepted the cycle after the result loads.
//   After reset the store is cleared one entry a cycle, all
//   NODE_COUNT << BLOCK_BITS entries (4096 with the defaults); s_tready
//   stays low until that pass ends. When the receiver stalls, the finished
//   result waits in the output register; one further item is accepted and
//   worked, then held until the register frees.
module sparse_radix_table
    import srt_pkg::*;
#(
    parameter int BLOCK_BITS = 4,
    parameter int NODE_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // index[15:0], value[47:16]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[31:0]
    output logic [1:0]  m_tuser    // found[0], pool_full[1]
);

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int STORE_AW = NODE_W + BLOCK_BITS;
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int EXT_W    = INDEX_W + LEVELS * BLOCK_BITS;
    localparam logic [FREE_W-1:0] NODE_COUNT_F = FREE_W'(NODE_COUNT);
    localparam logic [DATA_W-1:0] NODE_COUNT_D = DATA_W'(NODE_COUNT);
    localparam logic [1:0]        TOP_LEVEL    = 2'(LEVELS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [1:0]            level_reg, level_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic                  res_found_reg, res_found_next;
    logic                  res_full_reg, res_full_next;
    logic [DATA_W-1:0]     res_data_reg, res_data_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_full_reg, out_full_next;
    logic [DATA_W-1:0]     out_data_reg, out_data_next;

    logic [EXT_W-1:0]      index_ext;
    logic [BLOCK_BITS-1:0] digit;
    logic [STORE_AW-1:0]   slot;
    logic [FREE_W-1:0]     nodes_left;
    logic                  child_ok;
    logic                  mem_we;
    entry_t                mem_wdata;
    entry_t                mem_rdata;
    logic                  store_busy;

    srt_store #(
        .BLOCK_BITS (BLOCK_BITS),
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .addr    (slot),
        .wr_en   (mem_we),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata),
        .busy    (store_busy)
    );

    // digit of the current level and the entry it selects
    always_comb
    begin
        index_ext  = EXT_W'(index_reg);
        digit      = index_ext[level_reg * BLOCK_BITS +: BLOCK_BITS];
        slot       = {node_reg, digit};
        nodes_left = NODE_COUNT_F - free_reg;
        child_ok   = mem_rdata.valid && (mem_rdata.data < NODE_COUNT_D);
    end

    // walk, allocate and respond sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        node_next      = node_reg;
        level_next     = level_reg;
        free_next      = free_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;

        // output register drains independently
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !store_busy)
                begin
                    mode_next  = s_tuser[0];
                    index_next = s_tdata[15:0];
                    value_next = s_tdata[47:16];
                    node_next  = '0;
                    level_next = TOP_LEVEL;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_found_next = 1'b0;
                res_full_next  = 1'b0;
                res_data_next  = '0;
                if (level_reg != 2'd0 && child_ok)
                begin
                    // descend into the child node
                    node_next  = mem_rdata.data[NODE_W-1:0];
                    level_next = level_reg - 2'd1;
                    state_next = ST_LOOKUP;
                end
                else if (mode_reg == MODE_READ)
                begin
                    if (level_reg == 2'd0 && mem_rdata.valid)
                    begin
                        res_found_next = 1'b1;
                        res_data_next  = mem_rdata.data;
                    end
                    state_next = ST_RESP;
                end
                else if (FREE_W'(level_reg) > nodes_left)
                begin
                    // not enough nodes for the missing levels
                    res_full_next = 1'b1;
                    state_next    = ST_RESP;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (level_reg != 2'd0)
                begin
                    // link a fresh node and step down
                    mem_wdata.valid = 1'b1;
                    mem_wdata.data  = DATA_W'(free_reg);
                    node_next       = free_reg[NODE_W-1:0];
                    free_next       = free_reg + 1'b1;
                    level_next      = level_reg - 2'd1;
                end
                else
                begin
                    // leaf entry takes the payload
                    mem_wdata.valid = 1'b1;
                    mem_wdata.data  = value_reg;
                    res_found_next  = 1'b1;
                    res_data_next   = '0;
                    res_full_next   = 1'b0;
                    state_next      = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_full_next  = res_full_reg;
                    out_data_next  = res_data_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= FREE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        index_reg     <= index_next;
        value_reg     <= value_next;
        node_reg      <= node_next;
        level_reg     <= level_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        res_data_reg  <= res_data_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
        out_data_reg  <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && !store_busy;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_full_reg, out_found_reg};

endmodule

FILE: sim/sparse_radix_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sparse radix table: a short table of directed accesses,
// then random reads and writes under three idling mixes, checked against a tree predictor or typed-in answers.
// Depends on srt_pkg and the sparse_radix_table design files.
module sparse_radix_table_test;
    import srt_pkg::*;

    localparam int BLOCK_BITS    = 4;
    localparam int NODE_COUNT    = 256;
    localparam int STORE_DEPTH   = NODE_COUNT << BLOCK_BITS;
    localparam int DIGIT_MASK    = (1 << BLOCK_BITS) - 1;
    localparam int PHASE_ITEMS   = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam bit ROW_TYPED     = 1'b1;
    localparam bit ROW_MODEL     = 1'b0;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] read_value;
        logic              pool_full;
    } access_result_t;

    // how one accepted item is checked: typed-in answer or predictor
    typedef struct packed {
        logic           typed;
        access_result_t want;
    } check_plan_t;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  value;
        check_plan_t        plan;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // index[15:0], value[47:16]
    logic [0:0]  s_tuser;   // mode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_value[31:0]
    logic [1:0]  m_tuser;   // found[0], pool_full[1]

    // predictor copy of the tree
    logic [DATA_W-1:0]  tree_word [STORE_DEPTH];
    logic               tree_valid [STORE_DEPTH];
    int unsigned        free_node;

    check_plan_t        plan_q [$];
    access_result_t     due_q [$];
    logic [INDEX_W-1:0] written_q [$];
    stim_row_t          dir_rows [$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int cycle_count;

    sparse_radix_table #(
        .BLOCK_BITS(BLOCK_BITS),
        .NODE_COUNT(NODE_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // store position of the digit of idx at a level inside a node
    function automatic int unsigned digit_slot(input int unsigned node,
                                               input logic [INDEX_W-1:0] idx,
                                               input int level);
        digit_slot = (node << BLOCK_BITS) | ((int'(idx) >> (level * BLOCK_BITS)) & DIGIT_MASK);
    endfunction

    // walk the tree, allocate on writes, and return the access result
    function automatic access_result_t tree_access(input logic mode,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [DATA_W-1:0] val);
        int unsigned    node;
        int unsigned    slot;
        int unsigned    left;
        int             level;
        logic           stop;
        access_result_t res;
        res   = '0;
        node  = 0;
        level = LEVELS - 1;
        stop  = 1'b0;
        // descend while interior entries exist
        while (level > 0 && !stop)
        begin
            slot = digit_slot(node, idx, level);
            if (tree_valid[slot] && tree_word[slot] < NODE_COUNT)
            begin
                node  = tree_word[slot];
                level = level - 1;
            end
            else
                stop = 1'b1;
        end
        if (mode == MODE_READ)
        begin
            if (level == 0)
            begin
                slot = digit_slot(node, idx, 0);
                if (tree_valid[slot])
                begin
                    res.found      = 1'b1;
                    res.read_value = tree_word[slot];
                end
            end
        end
        else
        begin
            left = (free_node < NODE_COUNT) ? NODE_COUNT - free_node : 0;
            if (level > left)
                res.pool_full = 1'b1;
            else
            begin
                // hand out fresh nodes for every missing level
                while (level > 0)
                begin
                    slot             = digit_slot(node, idx, level);
                    tree_word[slot]  = free_node;
                    tree_valid[slot] = 1'b1;
                    node             = free_node;
                    free_node        = free_node + 1;
                    level            = level - 1;
                end
                slot             = digit_slot(node, idx, 0);
                tree_word[slot]  = val;
                tree_valid[slot] = 1'b1;
                res.found        = 1'b1;
            end
        end
        return res;
    endfunction

    // present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input check_plan_t plan);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        plan_q.push_back(plan);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random receiver stalls
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // predict on every accepted input item, check every accepted result item
    always @(posedge clk)
    begin
        access_result_t got;
        access_result_t want;
        check_plan_t    plan;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                plan = plan_q.pop_front();
                want = tree_access(s_tuser[0], s_tdata[15:0], s_tdata[47:16]);
                if (want.found && s_tuser[0] == MODE_WRITE)
                    written_q.push_back(s_tdata[15:0]);
                if (plan.typed)
                    want = plan.want;
                due_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata, m_tuser[1]};
                if (due_q.size() == 0)
                begin
                    $error("result item with no access pending");
                    fail_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %08h, got %08h",
                               want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.pool_full !== want.pool_full)
                    begin
                        $error("pool_full: expected %0d, got %0d",
                               want.pool_full, got.pool_full);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit, counted from the start including the clearing pass
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sparse_radix_table: mismatch");
        $finish;
    end

    initial
    begin
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  val;
        logic               mode;
        int                 pick;
        int                 lvl;
        int                 phase;
        int                 n;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        fail_count    = 0;
        send_idle_pct = 13;
        recv_idle_pct = 79;
        free_node     = 1;
        for (int i = 0; i < STORE_DEPTH; i++)
            tree_valid[i] = 1'b0;

        // directed rows: mode, index, value, check, found, read_value, pool_full
        dir_rows.push_back({MODE_READ,  16'h0000, 32'h0000_0000, ROW_TYPED, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'hFFFF, 32'hFFFF_FFFF, ROW_TYPED, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'h0000, 32'h0000_0000, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'hFFFF, 32'hFFFF_FFFF, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'hFFFF, 32'h0000_0000, ROW_TYPED,
                            1'b1, 32'hFFFF_FFFF, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h0000, 32'h0000_0000, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        // empty leaf entry, then paths that stop partway down
        dir_rows.push_back({MODE_READ,  16'hFFFE, 32'h0000_0000, ROW_TYPED, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'hF000, 32'h0000_0000, ROW_TYPED, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h0FFF, 32'h0000_0000, ROW_TYPED, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'hFFFE, 32'hA5A5_A5A5, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'hFFFE, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        // overwrite of a stored entry
        dir_rows.push_back({MODE_WRITE, 16'hFFFF, 32'h5A5A_5A5A, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'hFFFF, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'h1234, 32'h1234_5678, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h1234, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        // neighbors differing in one digit at each level
        dir_rows.push_back({MODE_READ,  16'h1235, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h1244, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h1334, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h2234, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'h0001, 32'hFFFF_FFFF, ROW_TYPED, 1'b1, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h0001, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_WRITE, 16'h8000, 32'h8000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});
        dir_rows.push_back({MODE_READ,  16'h8000, 32'h0000_0000, ROW_MODEL, 1'b0, 32'h0, 1'b0});

        // reset, released at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].index, dir_rows[i].value, dir_rows[i].plan);

        // random accesses, mostly around indices already stored
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct <= 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct <= 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (written_q.size() != 0 && pick < 40)
                    idx = written_q[$urandom_range(written_q.size() - 1)];
                else if (written_q.size() != 0 && pick < 70)
                begin
                    // same path except one digit
                    idx = written_q[$urandom_range(written_q.size() - 1)];
                    lvl = $urandom_range(LEVELS - 1);
                    idx[lvl * BLOCK_BITS +: BLOCK_BITS] = BLOCK_BITS'($urandom_range(DIGIT_MASK));
                end
                else if (pick < 92)
                    idx = INDEX_W'($urandom);
                else
                begin
                    case ($urandom_range(3))
                        0:       idx = 16'h0000;
                        1:       idx = 16'hFFFF;
                        2:       idx = 16'h8000;
                        default: idx = 16'h0001;
                    endcase
                end
                case ($urandom_range(9))
                    0:       val = 32'h0000_0000;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                mode = ($urandom_range(1) != 0) ? MODE_WRITE : MODE_READ;
                send_item(mode, idx, val, '0);
            end
        end
        s_tvalid <= 1'b0;

        // drain and let any stray result item show up
        while (plan_q.size() != 0 || due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("sparse_radix_table: match");
        else
            $display("sparse_radix_table: mismatch");
        $finish;
    end

endmodule

FILE: sparse_radix_table.f
design/srt_pkg.sv
design/srt_store.sv
design/sparse_radix_table.sv
sim/sparse_radix_table_test.sv
